>>> hdl/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// shared constants, types and the control store of the rc filter cascade
// ----------------------------------------------------------------------------
package rcf_pkg;

   // cascade size
   localparam int STAGES = 8;
   localparam int DEPTH  = 4 * STAGES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(STAGES + 1);

   // section state word: voltage over last input
   localparam int VOLT_W = 32;
   localparam int SAMP_W = 16;
   localparam int MEM_W  = VOLT_W + SAMP_W;

   // multiplier operands and product
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STAGE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEFFICIENT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN        = 2'd3;

   localparam logic [1:0]  MODE_LOW_PASS     = 2'd0;
   localparam logic [1:0]  MODE_HIGH_PASS    = 2'd1;
   localparam logic [1:0]  MODE_BAND_PASS    = 2'd2;

   localparam logic [1:0]  RESET_FILTER_MODE = MODE_LOW_PASS;
   localparam logic [3:0]  RESET_STAGE_COUNT = 4'd1;
   localparam logic [15:0] RESET_COEFFICIENT = 16'd4096;
   localparam logic [15:0] RESET_GAIN        = 16'd256;

   typedef struct packed {
      logic [1:0]  filter_mode;
      logic [3:0]  stage_count;
      logic [15:0] coefficient;
      logic [15:0] gain;
   } cfg_type;

   // sequencer branch conditions
   localparam logic [1:0] COND_NEXT   = 2'd0;  // fall through
   localparam logic [1:0] COND_ACCEPT = 2'd1;  // wait for input, skip if no stages
   localparam logic [1:0] COND_MORE   = 2'd2;  // loop while sections remain
   localparam logic [1:0] COND_EMIT   = 2'd3;  // wait for the output register

   localparam int PC_W     = 3;
   localparam int PROG_LEN = 7;

   // program steps
   localparam logic [PC_W-1:0] ST_IDLE = 3'd0;
   localparam logic [PC_W-1:0] ST_READ = 3'd1;
   localparam logic [PC_W-1:0] ST_LOAD = 3'd2;
   localparam logic [PC_W-1:0] ST_VNEW = 3'd3;
   localparam logic [PC_W-1:0] ST_GAIN = 3'd4;
   localparam logic [PC_W-1:0] ST_OUTX = 3'd5;
   localparam logic [PC_W-1:0] ST_EMIT = 3'd6;

   typedef struct packed {
      logic            req_rdy;   // input channel open
      logic            load_in;   // capture sample and reset section counters
      logic            mem_rd;    // read section state
      logic            load_v;    // latch state, multiply v by k
      logic            calc_v;    // new resistor voltage
      logic            mem_wr;    // write section state, multiply by gain
      logic            load_x;    // round section output, advance section
      logic            emit;      // hand result to output register
      logic [1:0]      cond;
      logic [PC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic accept;
      logic empty;
      logic more;
      logic out_busy;
   } seq_status_type;

   typedef struct packed {
      logic empty;
      logic more;
   } dp_status_type;

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type uw;
      uw = '0;
      unique case (pc)
         ST_IDLE: begin
            uw.req_rdy = 1'b1;
            uw.load_in = 1'b1;
            uw.cond    = COND_ACCEPT;
            uw.target  = ST_EMIT;
         end
         ST_READ: begin
            uw.mem_rd = 1'b1;
            uw.cond   = COND_NEXT;
         end
         ST_LOAD: begin
            uw.load_v = 1'b1;
            uw.cond   = COND_NEXT;
         end
         ST_VNEW: begin
            uw.calc_v = 1'b1;
            uw.cond   = COND_NEXT;
         end
         ST_GAIN: begin
            uw.mem_wr = 1'b1;
            uw.cond   = COND_NEXT;
         end
         ST_OUTX: begin
            uw.load_x = 1'b1;
            uw.cond   = COND_MORE;
            uw.target = ST_READ;
         end
         ST_EMIT: begin
            uw.emit   = 1'b1;
            uw.cond   = COND_EMIT;
            uw.target = ST_IDLE;
         end
         default: begin
            uw.cond   = COND_EMIT;
            uw.target = ST_IDLE;
         end
      endcase
      return uw;
   endfunction

endpackage

>>> hdl/rcf_ram.sv
// ----------------------------------------------------------------------------
// rcf_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module rcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rcf_useq.sv
// ----------------------------------------------------------------------------
// rcf_useq
// step counter and control store of the filter sequencer
// ----------------------------------------------------------------------------
module rcf_useq
   import rcf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  seq_status_type status,
   output uword_type      uword
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic [PC_W-1:0] pc_inc;

   assign uword  = ucode_rom(pc_ff);
   assign pc_inc = pc_ff + PC_W'(1);

   always_comb begin
      unique case (uword.cond)
         COND_NEXT:   pc_in = pc_inc;
         COND_ACCEPT: begin
            if (!status.accept) begin
               pc_in = pc_ff;
            end else if (status.empty) begin
               pc_in = uword.target;
            end else begin
               pc_in = pc_inc;
            end
         end
         COND_MORE:   pc_in = status.more ? uword.target : pc_inc;
         COND_EMIT:   pc_in = status.out_busy ? pc_ff : uword.target;
         default:     pc_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

`ifndef SYNTHESIS
   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      pc_ff < PC_W'(PROG_LEN))
      else $error("step counter left the program");
`endif

endmodule

>>> hdl/rcf_datapath.sv
// ----------------------------------------------------------------------------
// rcf_datapath
// section arithmetic, section state store and cascade position counters
// ----------------------------------------------------------------------------
module rcf_datapath
   import rcf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  uword_type                uword,
   input  logic                     accept,
   input  cfg_type                  cfg,
   input  logic signed [SAMP_W-1:0] sample_in,
   input  logic                     channel,
   output logic signed [SAMP_W-1:0] sample_result,
   output dp_status_type            status
);

   logic signed [SAMP_W-1:0]  x_ff;
   logic                      ch_ff;
   logic [CNT_W-1:0]          stage_ff;
   logic                      sect_ff;       // 1 high-pass, 0 low-pass
   logic signed [VOLT_W-1:0]  v_ff;
   logic signed [SAMP_W:0]    du_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [DEPTH-1:0]          valid_ff;

   logic [CNT_W-1:0]          n_stages;
   logic [CNT_W:0]            stage_inc;
   logic                      first_sect;
   logic                      more;
   logic [ADDR_W-1:0]         addr;
   logic [MEM_W-1:0]          rd_data;
   logic signed [VOLT_W-1:0]  rd_v;
   logic signed [SAMP_W-1:0]  rd_x;
   logic signed [MUL_A_W-1:0] gain_operand;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_full;
   logic signed [PROD_W-1:0]  vk_round;
   logic signed [34:0]        vsum;
   logic signed [VOLT_W-1:0]  v_new;
   logic signed [PROD_W-1:0]  out_round;
   logic signed [27:0]        out_wide;
   logic signed [SAMP_W-1:0]  out_sat;

   // stage count clamped to the cascade size
   always_comb begin
      if (int'(cfg.stage_count) > STAGES) begin
         n_stages = CNT_W'(STAGES);
      end else begin
         n_stages = CNT_W'(cfg.stage_count);
      end
   end

   assign first_sect = (cfg.filter_mode != MODE_LOW_PASS);
   assign stage_inc  = {1'b0, stage_ff} + (CNT_W + 1)'(1);
   // band-pass runs high then low within one stage
   assign more       = (sect_ff && cfg.filter_mode[1]) ||
                       (stage_inc < {1'b0, n_stages});

   assign status.empty = (n_stages == '0);
   assign status.more  = more;

   assign addr = ADDR_W'({stage_ff, sect_ff, ch_ff});

   rcf_ram #(
      .WIDTH (MEM_W),
      .DEPTH (DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (uword.mem_wr),
      .wr_addr (addr),
      .wr_data ({v_ff, x_ff}),
      .rd_en   (uword.mem_rd),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // never-written entries read as zero
   assign rd_v = valid_ff[addr] ? signed'(rd_data[MEM_W-1:SAMP_W]) : '0;
   assign rd_x = valid_ff[addr] ? signed'(rd_data[SAMP_W-1:0]) : '0;

   // shared multiplier: v*k, then v*gain or (x - v)*gain
   assign gain_operand = sect_ff ? MUL_A_W'(v_ff)
                                 : (MUL_A_W'(x_ff) <<< 15) - MUL_A_W'(v_ff);
   assign mul_a     = uword.mem_wr ? gain_operand : MUL_A_W'(rd_v);
   assign mul_b     = signed'({1'b0, (uword.mem_wr ? cfg.gain : cfg.coefficient)});
   assign prod_full = mul_a * mul_b;

   // v' = v + du*2^15 - round(v*k / 2^16), saturated
   assign vk_round = prod_ff + PROD_W'(32768);
   assign vsum     = 35'(v_ff) + (35'(du_ff) <<< 15) - signed'(vk_round[50:16]);
   assign v_new    = (&vsum[34:31] || ~|vsum[34:31]) ? vsum[31:0]
                                                     : {vsum[34], {31{~vsum[34]}}};

   // section output: round product / 2^23, saturated
   assign out_round = prod_ff + (PROD_W'(1) <<< 22);
   assign out_wide  = signed'(out_round[50:23]);
   assign out_sat   = (&out_wide[27:15] || ~|out_wide[27:15]) ? out_wide[15:0]
                                                              : {out_wide[27], {15{~out_wide[27]}}};

   always_ff @(posedge clock) begin
      if (uword.load_in && accept) begin
         x_ff  <= sample_in;
         ch_ff <= channel;
      end else if (uword.load_x) begin
         x_ff <= out_sat;
      end
      if (uword.load_v) begin
         v_ff  <= rd_v;
         du_ff <= 17'(x_ff) - 17'(rd_x);
      end else if (uword.calc_v) begin
         v_ff <= v_new;
      end
      if (uword.load_v || uword.mem_wr) begin
         prod_ff <= prod_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         sect_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         if (uword.load_in && accept) begin
            stage_ff <= '0;
            sect_ff  <= first_sect;
         end else if (uword.load_x) begin
            if (sect_ff && cfg.filter_mode[1]) begin
               sect_ff <= 1'b0;
            end else begin
               stage_ff <= stage_inc[CNT_W-1:0];
               sect_ff  <= first_sect;
            end
         end
         if (uword.mem_wr) begin
            valid_ff[addr] <= 1'b1;
         end
      end
   end

   assign sample_result = x_ff;

`ifndef SYNTHESIS
   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      uword.mem_wr |=> valid_ff[$past(addr)])
      else $error("state write did not mark its entry valid");
`endif

endmodule

>>> hdl/rc_filter_cascade_core.sv
// ----------------------------------------------------------------------------
// rc_filter_cascade_core
// cascade of first-order rc filter sections, one shared datapath run by a
// microcoded sequencer
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  req       in         req_valid / req_ready   req_sample_in, req_channel
//  rsp       out        rsp_valid / rsp_ready   rsp_sample_out
//  csr       in         csr_wr_en               csr_index, csr_data
//
//  one sample at a time: idle takes it, then read, load, vnew, gain and outx
//  run per section, then emit; sections being stage_count (clamped to
//  STAGES), doubled in band-pass; these steps come from the single shared
//  multiplier and the registered state ram read; zero stages: skips to emit
//  reset loads config defaults, clears sequencer and state valid bits at once
//  a held result stalls only the final step; the next sample can be taken
//  and filtered while the previous result waits in the output register
//
module rc_filter_cascade_core
   import rcf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // input transfer
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [SAMP_W-1:0] req_sample_in,
   input  logic                     req_channel,
   // result transfer
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SAMP_W-1:0] rsp_sample_out,
   // configuration writes
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   cfg_type                  cfg_ff;
   uword_type                uword;
   seq_status_type           seq_status;
   dp_status_type            dp_status;
   logic                     accept;
   logic                     out_busy;
   logic                     emit_fire;
   logic signed [SAMP_W-1:0] sample_result;
   logic                     rsp_valid_ff;
   logic signed [SAMP_W-1:0] rsp_sample_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_mode <= RESET_FILTER_MODE;
         cfg_ff.stage_count <= RESET_STAGE_COUNT;
         cfg_ff.coefficient <= RESET_COEFFICIENT;
         cfg_ff.gain        <= RESET_GAIN;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_FILTER_MODE: cfg_ff.filter_mode <= csr_data[1:0];
            REG_STAGE_COUNT: cfg_ff.stage_count <= csr_data[3:0];
            REG_COEFFICIENT: cfg_ff.coefficient <= csr_data;
            REG_GAIN:        cfg_ff.gain        <= csr_data;
            default:         ;
         endcase
      end
   end

   // handshake glue
   assign req_ready = uword.req_rdy;
   assign accept    = req_valid && uword.req_rdy;
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   // result may only enter the output register once the old one is taken
   assign emit_fire = uword.emit && !out_busy;

   assign seq_status.accept   = accept;
   assign seq_status.empty    = dp_status.empty;
   assign seq_status.more     = dp_status.more;
   assign seq_status.out_busy = out_busy;

   rcf_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (seq_status),
      .uword  (uword)
   );

   rcf_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .uword         (uword),
      .accept        (accept),
      .cfg           (cfg_ff),
      .sample_in     (req_sample_in),
      .channel       (req_channel),
      .sample_result (sample_result),
      .status        (dp_status)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_sample_ff <= sample_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

`ifndef SYNTHESIS
   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("input reopened right after a transfer");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(emit_fire))
      else $error("result appeared without an emit step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_sample_out))
      else $error("waiting result overwritten");
`endif

endmodule
